>>> rtl/lpe_pkg.sv
// Shared types and constants for the line position error unit.
package lpe_pkg;

    // Normalized sensor value: unsigned Q0.16 in [0, 1.0], 1.0 needs bit 16.
    localparam int NORM_FRAC = 16;
    localparam int NORM_W    = NORM_FRAC + 1;
    localparam logic [NORM_W-1:0] NORM_ONE      = NORM_W'(1) << NORM_FRAC;
    localparam logic [NORM_W-1:0] ON_LINE_LIMIT = NORM_W'(55705); // just below 0.85

    // Sum of three normalized values, doubled: 2 * 3 * 2^16 fits in 19 bits.
    localparam int DEN_W  = NORM_W + 2;
    // |nr - nl| * 5 fits in 20 bits.
    localparam int MAG5_W = NORM_W + 3;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_LOW    = 3'd0,
        CFG_LEFT_HIGH   = 3'd1,
        CFG_MIDDLE_LOW  = 3'd2,
        CFG_MIDDLE_HIGH = 3'd3,
        CFG_RIGHT_LOW   = 3'd4,
        CFG_RIGHT_HIGH  = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_DIV,
        ST_DONE
    } lpe_state_t;

endpackage

>>> rtl/lpe_norm_lane.sv
// One normalization lane: maps a sample to Q0.16 against its bounds with a serial divider.
module lpe_norm_lane #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SAMPLE_BITS-1:0]        sample,
    input  logic [SAMPLE_BITS-1:0]        low_bound,
    input  logic [SAMPLE_BITS-1:0]        high_bound,
    output logic                          busy,
    output logic [lpe_pkg::NORM_W-1:0]    norm
);
    import lpe_pkg::*;

    localparam int CNT_W = $clog2(NORM_FRAC + 1);

    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] div_reg;
    logic [NORM_FRAC-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   sat_reg;
    logic [SAMPLE_BITS:0]   shifted;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] span;

    assign diff = sample - low_bound;
    assign span = high_bound - low_bound;

    // one restoring step: remainder always stays below the divisor
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        if (shifted >= {1'b0, div_reg})
        begin
            rem_next = SAMPLE_BITS'(shifted - {1'b0, div_reg});
            quo_next = {quo_reg[NORM_FRAC-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[SAMPLE_BITS-1:0];
            quo_next = {quo_reg[NORM_FRAC-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (start)
        begin
            quo_reg <= '0;
            rem_reg <= diff;
            div_reg <= span;
            if (high_bound <= low_bound)
            begin
                sat_reg <= (sample > low_bound);
                cnt_reg <= '0;
            end
            else if (sample <= low_bound)
            begin
                sat_reg <= 1'b0;
                cnt_reg <= '0;
            end
            else if (diff >= span)
            begin
                sat_reg <= 1'b1;   // quotient at or above 1.0
                cnt_reg <= '0;
            end
            else
            begin
                sat_reg <= 1'b0;
                cnt_reg <= CNT_W'(NORM_FRAC);
            end
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign busy = (cnt_reg != '0);
    assign norm = sat_reg ? NORM_ONE : {1'b0, quo_reg};

endmodule

>>> rtl/lpe_ratio_div.sv
// Serial restoring divider for the error ratio, one quotient bit per cycle.
module lpe_ratio_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

>>> rtl/line_position_error_unit.sv
// Line position error unit: three-sensor weighted-centroid lateral error.
// Flow: the normalization lanes (skipped when all five lanes hit a fixed value), a merge
// step, then the ratio divider when on the line with a nonzero sum, and a done state that
// loads the result register. One item is in work at a time; the next transaction is
// accepted the cycle after the result loads.
// Reset (rst_n, async, active low) restores the default bounds and clears all history.
module line_position_error_unit #(
    parameter int SAMPLE_BITS     = 12,
    parameter int ERROR_FRAC_BITS = 15
) (
    input  logic clk,
    input  logic rst_n,

    // input stream
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // left_sample, middle_sample, right_sample (low bits up), zero padded
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,

    // result stream
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // position_error, on_line, turn_left_flag, turn_right_flag (low bits up), zero padded
    output logic [((ERROR_FRAC_BITS+4+7)/8)*8-1:0]      m_tdata,

    // configuration write channel
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [SAMPLE_BITS-1:0]                      cfg_data
);
    import lpe_pkg::*;

    localparam int IN_W  = ((3*SAMPLE_BITS+7)/8)*8;
    localparam int OUT_W = ((ERROR_FRAC_BITS+4+7)/8)*8;
    localparam int ERR_W = ERROR_FRAC_BITS + 1;
    localparam int NUM_W = MAG5_W + ERROR_FRAC_BITS;
    localparam int SB    = SAMPLE_BITS;

    localparam logic [ERR_W-1:0] FULL_POS = {1'b0, {ERROR_FRAC_BITS{1'b1}}};
    localparam logic [ERR_W-1:0] FULL_NEG = {1'b1, {ERROR_FRAC_BITS{1'b0}}};
    localparam logic [NUM_W-1:0] Q_POS_MAX = NUM_W'(FULL_POS);
    localparam logic [NUM_W-1:0] Q_NEG_MAX = NUM_W'(1) << ERROR_FRAC_BITS;

    lpe_state_t state_reg, state_next;

    // bound registers
    logic [SB-1:0] left_low_reg, left_high_reg;
    logic [SB-1:0] mid_low_reg, mid_high_reg;
    logic [SB-1:0] right_low_reg, right_high_reg;

    // history
    logic          err_neg_reg;
    logic [SB-1:0] prior_left_reg, prior_right_reg;
    logic          mark_left_reg, mark_right_reg;

    // item in work
    logic [SB-1:0]    cur_left_reg, cur_right_reg;
    logic             neg_reg;
    logic             on_reg;
    logic [ERR_W-1:0] err_reg;

    // output register
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic accept;
    logic lane_start;
    logic div_start;
    logic out_load;

    logic [SB-1:0] in_left, in_mid, in_right;
    assign in_left  = s_tdata[SB-1:0];
    assign in_mid   = s_tdata[2*SB-1:SB];
    assign in_right = s_tdata[3*SB-1:2*SB];

    // five lanes: the current three samples and the remembered left/right samples
    logic [NORM_W-1:0] n_left, n_mid, n_right, n_pleft, n_pright;
    logic [4:0]        lane_busy;

    lpe_norm_lane #(.SAMPLE_BITS(SB)) u_lane_left (
        .clk(clk), .rst_n(rst_n), .start(lane_start), .sample(in_left),
        .low_bound(left_low_reg), .high_bound(left_high_reg),
        .busy(lane_busy[0]), .norm(n_left)
    );
    lpe_norm_lane #(.SAMPLE_BITS(SB)) u_lane_mid (
        .clk(clk), .rst_n(rst_n), .start(lane_start), .sample(in_mid),
        .low_bound(mid_low_reg), .high_bound(mid_high_reg),
        .busy(lane_busy[1]), .norm(n_mid)
    );
    lpe_norm_lane #(.SAMPLE_BITS(SB)) u_lane_right (
        .clk(clk), .rst_n(rst_n), .start(lane_start), .sample(in_right),
        .low_bound(right_low_reg), .high_bound(right_high_reg),
        .busy(lane_busy[2]), .norm(n_right)
    );
    lpe_norm_lane #(.SAMPLE_BITS(SB)) u_lane_pleft (
        .clk(clk), .rst_n(rst_n), .start(lane_start), .sample(prior_left_reg),
        .low_bound(left_low_reg), .high_bound(left_high_reg),
        .busy(lane_busy[3]), .norm(n_pleft)
    );
    lpe_norm_lane #(.SAMPLE_BITS(SB)) u_lane_pright (
        .clk(clk), .rst_n(rst_n), .start(lane_start), .sample(prior_right_reg),
        .low_bound(right_low_reg), .high_bound(right_high_reg),
        .busy(lane_busy[4]), .norm(n_pright)
    );

    // merge: line detection, numerator and denominator of the ratio
    logic                on_now;
    logic                neg_now;
    logic [NORM_W-1:0]   mag;
    logic [MAG5_W-1:0]   mag5;
    logic [DEN_W-2:0]    sum3;
    logic [DEN_W-1:0]    den2;
    logic [NUM_W-1:0]    numer;

    assign on_now  = (n_left > ON_LINE_LIMIT) || (n_mid > ON_LINE_LIMIT)
                     || (n_right > ON_LINE_LIMIT);
    assign neg_now = (n_left > n_right);
    assign mag     = neg_now ? (n_left - n_right) : (n_right - n_left);
    assign mag5    = MAG5_W'({mag, 2'b00}) + MAG5_W'(mag);
    assign sum3    = (DEN_W-1)'(n_left) + (DEN_W-1)'(n_mid) + (DEN_W-1)'(n_right);
    assign den2    = {sum3, 1'b0};
    assign numer   = {mag5, {ERROR_FRAC_BITS{1'b0}}};

    logic             div_busy;
    logic [NUM_W-1:0] quo;

    lpe_ratio_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .numer(numer), .denom(den2),
        .busy(div_busy), .quotient(quo)
    );

    // truncated quotient, clamped to [-1, 1)
    logic [ERR_W-1:0] q_low;
    logic [ERR_W-1:0] err_div;
    assign q_low = quo[ERR_W-1:0];
    always_comb
    begin
        if (neg_reg)
            err_div = (quo > Q_NEG_MAX) ? FULL_NEG : ERR_W'(~q_low + ERR_W'(1));
        else
            err_div = (quo > Q_POS_MAX) ? FULL_POS : q_low;
    end

    logic merge_now;
    assign merge_now = (state_reg == ST_NORM) && (lane_busy == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_NORM;
            ST_NORM:
            begin
                if (lane_busy == '0)
                    state_next = (on_now && (sum3 != '0)) ? ST_DIV : ST_DONE;
            end
            ST_DIV:  if (!div_busy) state_next = ST_DONE;
            ST_DONE: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE);
        accept     = s_tready && s_tvalid;
        lane_start = accept;
        div_start  = merge_now && on_now && (sum3 != '0);
        out_load   = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            left_low_reg    <= '0;
            left_high_reg   <= '1;
            mid_low_reg     <= '0;
            mid_high_reg    <= '1;
            right_low_reg   <= '0;
            right_high_reg  <= '1;
            err_neg_reg     <= 1'b0;
            prior_left_reg  <= '0;
            prior_right_reg <= '0;
            mark_left_reg   <= 1'b0;
            mark_right_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_LEFT_LOW:    left_low_reg   <= cfg_data;
                    CFG_LEFT_HIGH:   left_high_reg  <= cfg_data;
                    CFG_MIDDLE_LOW:  mid_low_reg    <= cfg_data;
                    CFG_MIDDLE_HIGH: mid_high_reg   <= cfg_data;
                    CFG_RIGHT_LOW:   right_low_reg  <= cfg_data;
                    CFG_RIGHT_HIGH:  right_high_reg <= cfg_data;
                    default: ;   // unmapped index, write dropped
                endcase
            end

            if (merge_now)
            begin
                if (on_now)
                begin
                    mark_left_reg   <= 1'b0;
                    mark_right_reg  <= 1'b0;
                    prior_left_reg  <= cur_left_reg;
                    prior_right_reg <= cur_right_reg;
                end
                else if (n_pleft > ON_LINE_LIMIT)
                    mark_left_reg  <= 1'b1;
                else if (n_pright > ON_LINE_LIMIT)
                    mark_right_reg <= 1'b1;
            end

            // sign history follows only a real division
            if ((state_reg == ST_DIV) && !div_busy)
                err_neg_reg <= err_div[ERR_W-1];

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_left_reg  <= in_left;
            cur_right_reg <= in_right;
        end
        if (merge_now)
        begin
            on_reg  <= on_now;
            neg_reg <= neg_now;
            if (on_now)
                err_reg <= '0;   // zero denominator; overwritten after a division
            else if (n_pleft > ON_LINE_LIMIT)
                err_reg <= FULL_NEG;
            else if (n_pright > ON_LINE_LIMIT)
                err_reg <= FULL_POS;
            else
                err_reg <= err_neg_reg ? FULL_NEG : FULL_POS;
        end
        if ((state_reg == ST_DIV) && !div_busy)
            err_reg <= err_div;
        if (out_load)
            m_tdata_reg <= OUT_W'({mark_right_reg, mark_left_reg, on_reg, err_reg});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/lpe_checker.sv
// Port-level assertions for the line position error unit, bound to the top level.
module lpe_checker #(
    parameter int OUT_W = 24,
    parameter int FRAC  = 15
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    // one item in work: input side closes after a transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // turn marks are cleared on the line
    a_marks_clear_on_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[FRAC+1] |-> !m_tdata[FRAC+2] && !m_tdata[FRAC+3])
        else $error("turn mark set on an on-line result");

    // no result without a preceding input transaction
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !s_tready || $past(!s_tready))
        else $error("result appeared with no item in work");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
endmodule

bind line_position_error_unit lpe_checker #(
    .OUT_W(((ERROR_FRAC_BITS+4+7)/8)*8),
    .FRAC(ERROR_FRAC_BITS)
) u_lpe_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> test/tb_top.sv
// Self-checking testbench for the line position error unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lpe_pkg::*;

    localparam int SB = 12;
    localparam int FB = 15;
    localparam int IN_W  = ((3*SB+7)/8)*8;
    localparam int OUT_W = ((FB+4+7)/8)*8;
    localparam logic signed [FB:0] ERR_POS = (FB+1)'((1 << FB) - 1);
    localparam logic signed [FB:0] ERR_NEG = (FB+1)'(-(1 << FB));

    typedef struct packed {
        logic [SB-1:0] left;
        logic [SB-1:0] middle;
        logic [SB-1:0] right;
    } sensor_set_t;

    typedef struct packed {
        logic signed [FB:0] pos_err;
        logic               on_line;
        logic               turn_left;
        logic               turn_right;
    } steer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SB-1:0] cfg_data = '0;

    line_position_error_unit #(.SAMPLE_BITS(SB), .ERROR_FRAC_BITS(FB)) uut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Predictor state: bounds and line-tracking history
    logic [SB-1:0] lo_bound [3];
    logic [SB-1:0] hi_bound [3];
    logic          last_neg;
    logic [SB-1:0] last_left, last_right;
    logic          mark_left, mark_right;

    sensor_set_t pending_sets[$];
    steer_t      expected_steer[$];
    int          fail_count = 0;
    bit          hold_send = 1'b0;

    // Q0.16 normalization, saturating at 1.0
    function automatic logic [16:0] normalize(logic [SB-1:0] s, logic [SB-1:0] lo,
                                              logic [SB-1:0] hi);
        logic [31:0] q;
        if (hi <= lo) return (s > lo) ? 17'h10000 : 17'h0;
        if (s <= lo) return 17'h0;
        q = ({20'd0, s - lo} << 16) / {20'd0, hi - lo};
        return (q > 32'h10000) ? 17'h10000 : q[16:0];
    endfunction

    function automatic steer_t predict_steer(sensor_set_t x);
        steer_t r;
        logic [16:0] nl, nm, nr;
        logic [63:0] den, mag, q;
        nl = normalize(x.left, lo_bound[0], hi_bound[0]);
        nm = normalize(x.middle, lo_bound[1], hi_bound[1]);
        nr = normalize(x.right, lo_bound[2], hi_bound[2]);
        r.on_line = (nl > ON_LINE_LIMIT) || (nm > ON_LINE_LIMIT) || (nr > ON_LINE_LIMIT);
        if (r.on_line)
        begin
            den = 64'(nl) + 64'(nm) + 64'(nr);
            if (den == 0)
                r.pos_err = '0;
            else
            begin
                mag = (nl > nr) ? 64'(nl - nr) : 64'(nr - nl);
                q = ((mag * 5) << FB) / (den * 2);
                if (nl > nr)
                    r.pos_err = (q > (1 << FB)) ? ERR_NEG
                                                : (FB+1)'(-$signed({1'b0, q[FB:0]}));
                else
                    r.pos_err = (q > ERR_POS) ? ERR_POS : q[FB:0];
                last_neg = r.pos_err[FB];
            end
            mark_left = 1'b0;
            mark_right = 1'b0;
            last_left = x.left;
            last_right = x.right;
        end
        else if (normalize(last_left, lo_bound[0], hi_bound[0]) > ON_LINE_LIMIT)
        begin
            mark_left = 1'b1;
            r.pos_err = ERR_NEG;
        end
        else if (normalize(last_right, lo_bound[2], hi_bound[2]) > ON_LINE_LIMIT)
        begin
            mark_right = 1'b1;
            r.pos_err = ERR_POS;
        end
        else
            r.pos_err = last_neg ? ERR_NEG : ERR_POS;
        r.turn_left = mark_left;
        r.turn_right = mark_right;
        return r;
    endfunction

    // Mostly short gaps, occasionally long
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Input driver: one transaction per handshake, predicts on acceptance
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            expected_steer.push_back(predict_steer(pending_sets.pop_front()));
            send_gap <= gap_len();
        end
        if (!rst_n || hold_send)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !s_tready)
            ;
        else if (send_gap > 0 && !(s_tvalid && s_tready))
        begin
            send_gap <= send_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if ((s_tvalid && s_tready) ? pending_sets.size() > 0 && gap_len() == 0
                                        : pending_sets.size() > 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata <= IN_W'({pending_sets[0].right, pending_sets[0].middle,
                              pending_sets[0].left});
        end
        else
            s_tvalid <= 1'b0;
    end

    // Result monitor with random backpressure
    int stall = 0;
    always @(posedge clk)
    begin
        steer_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tdata[FB:0], m_tdata[FB+1], m_tdata[FB+2], m_tdata[FB+3]};
            if (expected_steer.size() == 0)
            begin
                $error("unexpected result transaction %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_steer.pop_front();
                if (got.pos_err !== want.pos_err)
                begin
                    $error("position_error exp %0d got %0d", want.pos_err, got.pos_err);
                    fail_count++;
                end
                if (got.on_line !== want.on_line)
                begin
                    $error("on_line exp %0b got %0b", want.on_line, got.on_line);
                    fail_count++;
                end
                if (got.turn_left !== want.turn_left)
                begin
                    $error("turn_left_flag exp %0b got %0b", want.turn_left, got.turn_left);
                    fail_count++;
                end
                if (got.turn_right !== want.turn_right)
                begin
                    $error("turn_right_flag exp %0b got %0b", want.turn_right, got.turn_right);
                    fail_count++;
                end
            end
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall > 0)
        begin
            stall <= stall - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (m_tvalid && m_tready)
                stall <= gap_len();
        end
    end

    task automatic write_bound(cfg_idx_t idx, logic [SB-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx[0]) hi_bound[idx >> 1] = val;
        else        lo_bound[idx >> 1] = val;
    endtask

    // Block is idle once queues drain plus the longest pipeline latency
    task automatic drain();
        while (pending_sets.size() > 0 || expected_steer.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic queue_set(logic [SB-1:0] l, logic [SB-1:0] m, logic [SB-1:0] r);
        pending_sets.push_back('{l, m, r});
    endtask

    // Line-following run: random readings mixed with dark left, dark right, near-threshold middle and lost-line sets
    task automatic random_run(int n);
        sensor_set_t x;
        for (int i = 0; i < n; i++)
        begin
            x.left = SB'($urandom); x.middle = SB'($urandom); x.right = SB'($urandom);
            case ($urandom_range(5))
                0: begin x.left = SB'($urandom_range(4095, 3400)); end
                1: begin x.right = SB'($urandom_range(4095, 3400)); end
                2: begin x.left = SB'($urandom_range(1500)); x.middle = SB'($urandom_range(1500));
                         x.right = SB'($urandom_range(1500)); end
                3: begin x.middle = SB'($urandom_range(3560, 3400)); end
                default: ;
            endcase
            pending_sets.push_back(x);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo_bound[i] = '0;
            hi_bound[i] = 12'hFFF;
        end
        last_neg = 1'b0; last_left = '0; last_right = '0;
        mark_left = 1'b0; mark_right = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, threshold edge (3481 = just over 0.85 at full range),
        // lost line after left dark, after right dark, and with no dark prior
        queue_set(12'h000, 12'h000, 12'h000);
        queue_set(12'hFFF, 12'hFFF, 12'hFFF);
        queue_set(12'hFFF, 12'h000, 12'h000);
        queue_set(12'h000, 12'h000, 12'h000);
        queue_set(12'h000, 12'h000, 12'hFFF);
        queue_set(12'h000, 12'h000, 12'h000);
        queue_set(12'h000, 12'd3481, 12'h000);
        queue_set(12'd3480, 12'd3480, 12'd3480);
        queue_set(12'hFFF, 12'hFFF, 12'h000);
        queue_set(12'h000, 12'h000, 12'h000);
        queue_set(12'h555, 12'hAAA, 12'hFFF);
        queue_set(12'hAAA, 12'h555, 12'h000);
        drain();

        // Inverted and empty ranges, sample above high bound
        write_bound(CFG_LEFT_LOW, 12'd2000);
        write_bound(CFG_LEFT_HIGH, 12'd1000);
        write_bound(CFG_MIDDLE_LOW, 12'd500);
        write_bound(CFG_MIDDLE_HIGH, 12'd500);
        write_bound(CFG_RIGHT_LOW, 12'd100);
        write_bound(CFG_RIGHT_HIGH, 12'd900);
        queue_set(12'd2001, 12'd0, 12'd0);
        queue_set(12'd2000, 12'd500, 12'd99);
        queue_set(12'd0, 12'd501, 12'd4095);
        queue_set(12'd0, 12'd0, 12'd0);
        queue_set(12'd0, 12'd0, 12'd880);
        drain();

        // Sender holds while a random run is queued, then releases it
        hold_send = 1'b1;
        random_run(30);
        repeat (50) @(posedge clk);
        hold_send = 1'b0;
        drain();

        // Random phases across bound settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int k = 0; k < 6; k++)
            begin
                logic [SB-1:0] v;
                case (ph)
                    0: v = k[0] ? 12'hFFF : 12'h000;
                    1: v = k[0] ? 12'h000 : 12'hFFF;
                    default: v = k[0] ? SB'($urandom_range(4095, 2500))
                                      : SB'($urandom_range(1600));
                endcase
                write_bound(cfg_idx_t'(k), v);
            end
            random_run(300);
            drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule
